// File: hdl/sspseq_pkg.sv
// shared types and constants for the servo slew and power sequencer
// no dependencies
`default_nettype none

package sspseq_pkg;

  // phase codes, as reported on the phase port
  typedef enum logic [1:0] {
    PH_MOVING  = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_OFF     = 2'd2,
    PH_REFRESH = 2'd3
  } phase_t;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_CLOSED_POSITION = 3'd0;
  localparam logic [2:0] REG_THROWN_POSITION = 3'd1;
  localparam logic [2:0] REG_SLEW_STEP       = 3'd2;
  localparam logic [2:0] REG_SETTLE_TICKS    = 3'd3;
  localparam logic [2:0] REG_OFF_TICKS       = 3'd4;
  localparam logic [2:0] REG_REFRESH_TICKS   = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register reset values
  localparam logic [7:0] RST_CLOSED_POSITION = 8'd0;
  localparam logic [7:0] RST_THROWN_POSITION = 8'd0;
  localparam logic [7:0] RST_SLEW_STEP       = 8'd1;
  localparam logic [7:0] RST_SETTLE_TICKS    = 8'd20;
  localparam logic [7:0] RST_OFF_TICKS       = 8'd100;
  localparam logic [7:0] RST_REFRESH_TICKS   = 8'd10;

  // configuration set seen by the step logic
  typedef struct packed {
    logic [7:0] closed_position;
    logic [7:0] thrown_position;
    logic [7:0] slew_step;
    logic [7:0] settle_ticks;
    logic [7:0] off_ticks;
    logic [7:0] refresh_ticks;
  } cfg_t;

  // sequencer state carried from tick to tick
  typedef struct packed {
    logic [7:0] position;
    phase_t     phase;
    logic [7:0] tick_count;
  } seq_state_t;

endpackage

`default_nettype wire

// File: hdl/servo_slew_power_sequencer.sv
// servo slew and power sequencer: top level with register port and result register
// depends on sspseq_pkg and sspseq_step
//
// latency: the result word for a tick is valid the cycle after the tick is accepted
// throughput: one tick per cycle with result_ready high, as each result drains
// reset: synchronous rst clears state to position 0, moving phase, count 0,
//   and loads the register reset values; no clearing pass
`default_nettype none

module servo_slew_power_sequencer
  import sspseq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // tick channel
  input  wire logic              tick_valid,
  output logic                   tick_ready,
  input  wire logic              direction,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [7:0]             position,
  output logic                   powered,
  output logic [1:0]             phase,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  logic       tick_take;
  logic       cfg_write;
  logic [2:0] reg_index;
  logic [7:0] read_byte;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_index = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closed_position <= RST_CLOSED_POSITION;
      cfg.thrown_position <= RST_THROWN_POSITION;
      cfg.slew_step       <= RST_SLEW_STEP;
      cfg.settle_ticks    <= RST_SETTLE_TICKS;
      cfg.off_ticks       <= RST_OFF_TICKS;
      cfg.refresh_ticks   <= RST_REFRESH_TICKS;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CLOSED_POSITION: cfg.closed_position <= pwdata[7:0];
        REG_THROWN_POSITION: cfg.thrown_position <= pwdata[7:0];
        REG_SLEW_STEP:       cfg.slew_step       <= pwdata[7:0];
        REG_SETTLE_TICKS:    cfg.settle_ticks    <= pwdata[7:0];
        REG_OFF_TICKS:       cfg.off_ticks       <= pwdata[7:0];
        REG_REFRESH_TICKS:   cfg.refresh_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      REG_CLOSED_POSITION: read_byte = cfg.closed_position;
      REG_THROWN_POSITION: read_byte = cfg.thrown_position;
      REG_SLEW_STEP:       read_byte = cfg.slew_step;
      REG_SETTLE_TICKS:    read_byte = cfg.settle_ticks;
      REG_OFF_TICKS:       read_byte = cfg.off_ticks;
      REG_REFRESH_TICKS:   read_byte = cfg.refresh_ticks;
      default:             read_byte = 8'd0;
    endcase
    prdata = {{(DATA_W-8){1'b0}}, read_byte};
  end

  // a tick is taken whenever the result register is free or draining
  assign tick_ready = ~result_valid | result_ready;
  assign tick_take  = tick_valid & tick_ready;

  sspseq_step u_step (
    .direction  (direction),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.position   <= 8'd0;
      state.phase      <= PH_MOVING;
      state.tick_count <= 8'd0;
    end else if (tick_take) begin
      state <= state_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      position <= state_next.position;
      powered  <= (state_next.phase != PH_OFF);
      phase    <= state_next.phase;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sspseq_step.sv
// next-state logic for one tick: slew toward target, then timed power phases
// depends on sspseq_pkg
`default_nettype none

module sspseq_step
  import sspseq_pkg::*;
(
  input  wire logic       direction,
  input  wire cfg_t       cfg,
  input  wire seq_state_t state,
  output seq_state_t      state_next
);

  logic [7:0] target;
  logic [7:0] diff;
  logic [7:0] slewed;
  logic [7:0] tick_inc;
  logic [7:0] limit;
  phase_t     after_limit;

  // target select and clamped slew
  always_comb begin
    target = direction ? cfg.thrown_position : cfg.closed_position;
    if (state.position < target) begin
      diff   = target - state.position;
      slewed = (diff <= cfg.slew_step) ? target : state.position + cfg.slew_step;
    end else begin
      diff   = state.position - target;
      slewed = (diff <= cfg.slew_step) ? target : state.position - cfg.slew_step;
    end
  end

  // limit and follow-on phase for the timed phases
  always_comb begin
    tick_inc = state.tick_count + 8'd1;
    case (state.phase)
      PH_SETTLE: begin
        limit       = cfg.settle_ticks;
        after_limit = PH_OFF;
      end
      PH_OFF: begin
        limit       = cfg.off_ticks;
        after_limit = PH_REFRESH;
      end
      PH_REFRESH: begin
        limit       = cfg.refresh_ticks;
        after_limit = PH_OFF;
      end
      default: begin
        limit       = cfg.refresh_ticks;
        after_limit = PH_OFF;
      end
    endcase
  end

  // phase update
  always_comb begin
    state_next = state;
    if (state.position != target) begin
      state_next.phase    = PH_MOVING;
      state_next.position = slewed;
    end else if (state.phase == PH_MOVING) begin
      state_next.phase      = PH_SETTLE;
      state_next.tick_count = 8'd0;
    end else if (tick_inc == limit) begin
      state_next.phase      = after_limit;
      state_next.tick_count = 8'd0;
    end else begin
      state_next.tick_count = tick_inc;
    end
  end

endmodule

`default_nettype wire

// File: test/servo_slew_power_sequencer_tb.sv
`timescale 1ns / 1ps
// testbench for servo_slew_power_sequencer: directed table, then random ticks with stalls
// results are checked against an in-bench tick predictor; depends on sspseq_pkg and the dut

module servo_slew_power_sequencer_tb;
  import sspseq_pkg::*;

  // unused register slots, writes there must not change anything
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int NUM_ROWS = 34;
  localparam int DRAIN_LIMIT = 100000;

  typedef struct packed {
    logic [7:0] position;
    logic       powered;
    phase_t     phase;
  } servo_word_t;

  typedef struct packed {
    logic        is_write;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic        dir;
    logic        typed;
    servo_word_t word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic tick_valid, tick_ready, direction;
  logic result_valid, result_ready;
  logic [7:0] position;
  logic powered;
  logic [1:0] phase;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  // predictor copy of registers and sequencer state
  logic [7:0] cfg_closed, cfg_thrown, cfg_slew, cfg_settle, cfg_off, cfg_refresh;
  logic [7:0] model_pos, model_count;
  phase_t     model_phase;

  servo_word_t pending_servo_words[$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;
  dir_row_t directed_rows [NUM_ROWS];

  servo_slew_power_sequencer u_dut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .direction(direction),
    .result_valid(result_valid), .result_ready(result_ready),
    .position(position), .powered(powered), .phase(phase),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one tick of the sequencer, returns the word it should report
  function automatic servo_word_t advance_servo(input logic dir);
    logic [7:0] target, limit;
    phase_t nxt;
    servo_word_t w;
    target = dir ? cfg_thrown : cfg_closed;
    if (model_pos != target) begin
      model_phase = PH_MOVING;
      // slew toward target, clamp at target instead of wrapping
      if (model_pos < target)
        model_pos = (target - model_pos <= cfg_slew) ? target : model_pos + cfg_slew;
      else
        model_pos = (model_pos - target <= cfg_slew) ? target : model_pos - cfg_slew;
    end else if (model_phase == PH_MOVING) begin
      model_phase = PH_SETTLE;
      model_count = 8'd0;
    end else begin
      // timed phases
      case (model_phase)
        PH_SETTLE: begin limit = cfg_settle;  nxt = PH_OFF;     end
        PH_OFF:    begin limit = cfg_off;     nxt = PH_REFRESH; end
        default:   begin limit = cfg_refresh; nxt = PH_OFF;     end
      endcase
      model_count = model_count + 8'd1;
      if (model_count == limit) begin
        model_phase = nxt;
        model_count = 8'd0;
      end
    end
    w.position = model_pos;
    w.powered  = (model_phase != PH_OFF);
    w.phase    = model_phase;
    return w;
  endfunction

  function automatic dir_row_t write_row(input logic [2:0] idx, input logic [31:0] data);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.wdata    = data;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic dir, input logic typed,
                                        input logic [7:0] pos, input logic pwr,
                                        input phase_t ph);
    dir_row_t r;
    r = '0;
    r.dir   = dir;
    r.typed = typed;
    r.word.position = pos;
    r.word.powered  = pwr;
    r.word.phase    = ph;
    return r;
  endfunction

  function automatic logic [7:0] pick_position();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // register write, setup then access; called and returns at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CLOSED_POSITION: cfg_closed  = data[7:0];
      REG_THROWN_POSITION: cfg_thrown  = data[7:0];
      REG_SLEW_STEP:       cfg_slew    = data[7:0];
      REG_SETTLE_TICKS:    cfg_settle  = data[7:0];
      REG_OFF_TICKS:       cfg_off     = data[7:0];
      REG_REFRESH_TICKS:   cfg_refresh = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // offer one tick word in bursts with random gaps; called and returns at a falling edge
  task automatic send_tick(input logic dir, input logic typed, input servo_word_t typed_word);
    int gap;
    servo_word_t w;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        tick_valid <= 1'b0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    tick_valid <= 1'b1;
    direction <= dir;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    w = advance_servo(dir);
    pending_servo_words.push_back(typed ? typed_word : w);
    burst_left--;
    @(negedge clk);
  endtask

  // stop offering and wait for every expected word, then a short pause
  task automatic drain_results();
    int waited;
    waited = 0;
    tick_valid <= 1'b0;
    while (pending_servo_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_servo_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_servo_words.size());
      mismatch_count++;
      pending_servo_words.delete();
    end
    repeat (3) @(negedge clk);
  endtask

  // result side: own stall pattern plus long hold-offs on request
  initial begin
    int mode, mode_left, hold_left, cyc;
    logic rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 150;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (cyc % 7 != 3) && (cyc % 7 != 4);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      result_ready <= rdy;
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_words
    servo_word_t exp_w;
    if (!rst && result_valid && result_ready) begin
      if (pending_servo_words.size() == 0) begin
        $display("%0t: unexpected word position %0d powered %0d phase %0d",
                 $time, position, powered, phase);
        mismatch_count++;
      end else begin
        exp_w = pending_servo_words.pop_front();
        if (position !== exp_w.position) begin
          $display("%0t: position expected %0d got %0d", $time, exp_w.position, position);
          mismatch_count++;
        end
        if (powered !== exp_w.powered) begin
          $display("%0t: powered expected %0d got %0d", $time, exp_w.powered, powered);
          mismatch_count++;
        end
        if (phase !== exp_w.phase) begin
          $display("%0t: phase expected %0d got %0d", $time, exp_w.phase, phase);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n, run_left;
    logic cur_dir;
    logic [7:0] slew_v, count_v;
    rst = 1'b1;
    tick_valid = 1'b0;
    direction = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_closed  = RST_CLOSED_POSITION;
    cfg_thrown  = RST_THROWN_POSITION;
    cfg_slew    = RST_SLEW_STEP;
    cfg_settle  = RST_SETTLE_TICKS;
    cfg_off     = RST_OFF_TICKS;
    cfg_refresh = RST_REFRESH_TICKS;
    model_pos   = 8'd0;
    model_count = 8'd0;
    model_phase = PH_MOVING;

    // directed table: reset values, full-range slews, clamps, short timed phases,
    // zero slew step, unused register slots, upper data bits ignored
    directed_rows = '{
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_SETTLE),
      tick_row(1'b1, 1'b1, 8'd0,   1'b1, PH_SETTLE),
      write_row(REG_THROWN_POSITION, 32'd255),
      write_row(REG_SLEW_STEP, 32'd255),
      tick_row(1'b1, 1'b1, 8'd255, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_MOVING),
      write_row(REG_SLEW_STEP, 32'd100),
      write_row(REG_CLOSED_POSITION, 32'd250),
      tick_row(1'b0, 1'b1, 8'd100, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd200, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd250, 1'b1, PH_MOVING),
      tick_row(1'b1, 1'b1, 8'd255, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd250, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd250, 1'b1, PH_SETTLE),
      write_row(REG_CLOSED_POSITION, 32'd0),
      tick_row(1'b0, 1'b1, 8'd150, 1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd50,  1'b1, PH_MOVING),
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_MOVING),
      write_row(REG_SETTLE_TICKS, 32'd1),
      write_row(REG_OFF_TICKS, 32'd1),
      write_row(REG_REFRESH_TICKS, 32'd1),
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_SETTLE),
      tick_row(1'b0, 1'b1, 8'd0,   1'b0, PH_OFF),
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_REFRESH),
      tick_row(1'b0, 1'b1, 8'd0,   1'b0, PH_OFF),
      write_row(REG_SLEW_STEP, 32'd0),
      tick_row(1'b1, 1'b1, 8'd0,   1'b1, PH_MOVING),
      tick_row(1'b1, 1'b1, 8'd0,   1'b1, PH_MOVING),
      write_row(REG_SPARE_A, 32'hAAAA_AAAA),
      write_row(REG_SPARE_B, 32'h5555_5555),
      tick_row(1'b0, 1'b1, 8'd0,   1'b1, PH_SETTLE),
      write_row(REG_SLEW_STEP, 32'hFFFF_FF03),
      tick_row(1'b1, 1'b0, 8'd0,   1'b0, PH_MOVING),
      tick_row(1'b1, 1'b0, 8'd0,   1'b0, PH_MOVING)
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
      end else begin
        send_tick(directed_rows[i].dir, directed_rows[i].typed, directed_rows[i].word);
      end
    end

    // random phases; phase 3 has zero tick registers (256-tick phases),
    // phase 6 the longest nonzero ones
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       slew_v = 8'd255;
        1:       slew_v = 8'd1;
        2:       slew_v = 8'd0;
        default: slew_v = 8'($urandom_range(2, 80));
      endcase
      if (p == 3) slew_v = 8'd255;
      write_reg(REG_CLOSED_POSITION, {24'($urandom()), pick_position()});
      write_reg(REG_THROWN_POSITION, {24'($urandom()), pick_position()});
      write_reg(REG_SLEW_STEP, {24'($urandom()), slew_v});
      for (int r = 0; r < 3; r++) begin
        count_v = (p == 3) ? 8'd0 : (p == 6) ? 8'd255 : 8'($urandom_range(1, 6));
        write_reg(r == 0 ? REG_SETTLE_TICKS : r == 1 ? REG_OFF_TICKS : REG_REFRESH_TICKS,
                  {24'($urandom()), count_v});
      end
      if (p == 2 || p == 5) hold_request = 1'b1;

      // mostly long same-direction runs, some short flips as noise
      n = (p == 3) ? 560 : 80;
      run_left = 0;
      for (int k = 0; k < n; k++) begin
        if (run_left == 0) begin
          cur_dir = 1'($urandom_range(0, 1));
          if (p == 3)
            run_left = n;
          else if ($urandom_range(0, 4) == 0)
            run_left = $urandom_range(1, 3);
          else
            run_left = $urandom_range(8, 60);
        end
        run_left--;
        send_tick(cur_dir, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
